### rtl/core/bqc_pkg.sv
// shared constants, codes and tables for the biquad coefficient generator
`default_nettype none

package bqc_pkg;

	localparam int COEF_WIDTH     = 32;
	localparam int COEF_FRAC_BITS = 24;
	localparam int TAN_ITERATIONS = 24;

	localparam int CFG_ADDR_WIDTH = 5;
	localparam int CFG_DATA_WIDTH = 32;
	localparam int FS_WIDTH       = 18;
	localparam int FREQ_WIDTH     = 17;

	// pi in Q30 and the cordic start vector
	localparam logic [31:0] PI_Q      = 32'd3373259426;
	localparam logic [31:0] CORDIC_X0 = 32'd536870912;

	typedef enum logic [2:0] {
		REG_NUM_C0 = 3'd0,
		REG_NUM_C1 = 3'd1,
		REG_NUM_C2 = 3'd2,
		REG_DEN_C0 = 3'd3,
		REG_DEN_C1 = 3'd4,
		REG_DEN_C2 = 3'd5,
		REG_FS     = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_ZERO  = 2'd2,
		ST_SAT   = 2'd3
	} status_t;

	localparam logic [31:0] RST_ONE = 32'd16777216;
	localparam logic [17:0] RST_FS  = 18'd48000;

	// arctangent of 2^-i in Q30, rounded
	function automatic logic [31:0] atan_step(input int unsigned i);
		logic [31:0] r;
		case (i)
			0:       r = 32'd843314857;
			1:       r = 32'd497837829;
			2:       r = 32'd263043837;
			3:       r = 32'd133525159;
			4:       r = 32'd67021687;
			5:       r = 32'd33543516;
			6:       r = 32'd16775851;
			7:       r = 32'd8388437;
			8:       r = 32'd4194283;
			9:       r = 32'd2097149;
			10:      r = 32'd1048576;
			31:      r = 32'd1;
			default: r = (i <= 30) ? (32'd1 << (30 - i)) : 32'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/core/biquad_bilinear_coefficient_gen.sv
// prewarped bilinear biquad coefficient generator, top level
`default_nettype none

// One request per cycle: start is taken at every edge (busy stays low) and the
// results appear with done at the end of the pipeline: a 31-stage restoring divider
// for the angle, one cordic stage per iteration, and a COEF_WIDTH+1 stage divider
// for the five quotients. The receiver cannot stall: results stand on the ports for
// one cycle only. Configuration registers must be written only while no request is
// in flight.
module biquad_bilinear_coefficient_gen #(
	parameter int COEF_WIDTH     = bqc_pkg::COEF_WIDTH,
	parameter int COEF_FRAC_BITS = bqc_pkg::COEF_FRAC_BITS,
	parameter int TAN_ITERATIONS = bqc_pkg::TAN_ITERATIONS
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [bqc_pkg::CFG_ADDR_WIDTH-1:0]   paddr,
	input  wire logic [bqc_pkg::CFG_DATA_WIDTH-1:0]   pwdata,
	output logic      [bqc_pkg::CFG_DATA_WIDTH-1:0]   prdata,
	output logic                                       pready,
	input  wire logic                                  start,
	input  wire logic [bqc_pkg::FREQ_WIDTH-1:0]       cutoff_hz,
	output logic                                       busy,
	output logic                                       done,
	output logic signed [COEF_WIDTH-1:0]               coef_b0,
	output logic signed [COEF_WIDTH-1:0]               coef_b1,
	output logic signed [COEF_WIDTH-1:0]               coef_b2,
	output logic signed [COEF_WIDTH-1:0]               coef_a1,
	output logic signed [COEF_WIDTH-1:0]               coef_a2,
	output logic      [1:0]                            status
);

	localparam int W    = COEF_WIDTH;
	localparam int F    = COEF_FRAC_BITS;
	localparam int T    = TAN_ITERATIONS;
	localparam int SW_  = bqc_pkg::FS_WIDTH;
	localparam int AQ   = 31;
	localparam int AW   = 49;
	localparam int SQ   = 34;
	localparam int SW   = 70;
	localparam int RW   = SW + W + F + 2;
	localparam int LAT  = T + W + 38;

	// configuration
	logic signed [31:0]     num_q [0:2];
	logic signed [31:0]     den_q [0:2];
	logic        [SW_-1:0]  fs_q;
	logic                   cfg_wr;
	bqc_pkg::reg_idx_t      cfg_idx;

	assign pready  = 1'b1;
	assign busy    = 1'b0;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = bqc_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q[0] <= bqc_pkg::RST_ONE;
			num_q[1] <= '0;
			num_q[2] <= '0;
			den_q[0] <= bqc_pkg::RST_ONE;
			den_q[1] <= '0;
			den_q[2] <= '0;
			fs_q     <= bqc_pkg::RST_FS;
		end else if (cfg_wr) begin
			case (cfg_idx)
				bqc_pkg::REG_NUM_C0: num_q[0] <= pwdata;
				bqc_pkg::REG_NUM_C1: num_q[1] <= pwdata;
				bqc_pkg::REG_NUM_C2: num_q[2] <= pwdata;
				bqc_pkg::REG_DEN_C0: den_q[0] <= pwdata;
				bqc_pkg::REG_DEN_C1: den_q[1] <= pwdata;
				bqc_pkg::REG_DEN_C2: den_q[2] <= pwdata;
				bqc_pkg::REG_FS:     fs_q     <= pwdata[SW_-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			bqc_pkg::REG_NUM_C0: prdata = num_q[0];
			bqc_pkg::REG_NUM_C1: prdata = num_q[1];
			bqc_pkg::REG_NUM_C2: prdata = num_q[2];
			bqc_pkg::REG_DEN_C0: prdata = den_q[0];
			bqc_pkg::REG_DEN_C1: prdata = den_q[1];
			bqc_pkg::REG_DEN_C2: prdata = den_q[2];
			bqc_pkg::REG_FS:     prdata = 32'(fs_q);
			default:             prdata = '0;
		endcase
	end

	// stage 1: range check and pi * f
	logic          v_s1;
	logic          bad_s1;
	logic [AW-1:0] aprod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		bad_s1   <= (cutoff_hz == '0) | ({cutoff_hz, 1'b0} >= fs_q);
		aprod_s1 <= AW'(bqc_pkg::PI_Q * cutoff_hz);
	end

	// angle divider, one quotient bit per stage
	logic [AW-1:0] arem_s [0:AQ];
	logic [AQ-1:0] aq_s   [0:AQ];
	logic          av_s   [0:AQ];
	logic          abad_s [0:AQ];

	assign arem_s[0] = aprod_s1;
	assign aq_s[0]   = '0;
	assign av_s[0]   = v_s1;
	assign abad_s[0] = bad_s1;

	for (genvar k = 0; k < AQ; k++) begin : g_ang
		localparam int B = AQ - 1 - k;
		logic [AW:0] sh;
		logic        geq;
		assign sh  = (AW + 1)'(fs_q) << B;
		assign geq = {1'b0, arem_s[k]} >= sh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				av_s[k+1] <= 1'b0;
			end else begin
				av_s[k+1] <= av_s[k];
			end
		end

		always_ff @(posedge clk) begin
			abad_s[k+1]    <= abad_s[k];
			arem_s[k+1]    <= geq ? arem_s[k] - sh[AW-1:0] : arem_s[k];
			aq_s[k+1]      <= aq_s[k] | (AQ'(geq) << B);
		end
	end

	// cordic rotation, one iteration per stage
	logic signed [31:0] cx_s   [0:T];
	logic signed [31:0] cy_s   [0:T];
	logic signed [32:0] cz_s   [0:T];
	logic               cv_s   [0:T];
	logic               cbad_s [0:T];

	assign cx_s[0]   = bqc_pkg::CORDIC_X0;
	assign cy_s[0]   = '0;
	assign cz_s[0]   = {2'b00, aq_s[AQ]};
	assign cv_s[0]   = av_s[AQ];
	assign cbad_s[0] = abad_s[AQ];

	for (genvar j = 0; j < T; j++) begin : g_cordic
		localparam logic signed [32:0] A = 33'(bqc_pkg::atan_step(j));
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		assign dx = cy_s[j] >>> j;
		assign dy = cx_s[j] >>> j;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[j+1] <= 1'b0;
			end else begin
				cv_s[j+1] <= cv_s[j];
			end
		end

		always_ff @(posedge clk) begin
			cbad_s[j+1] <= cbad_s[j];
			if (!cz_s[j][32]) begin
				cx_s[j+1] <= cx_s[j] - dx;
				cy_s[j+1] <= cy_s[j] + dy;
				cz_s[j+1] <= cz_s[j] - A;
			end else begin
				cx_s[j+1] <= cx_s[j] + dx;
				cy_s[j+1] <= cy_s[j] - dy;
				cz_s[j+1] <= cz_s[j] + A;
			end
		end
	end

	// stage 2: squares and cross product in Q30
	logic signed [63:0] ssf, csf, ccf;
	logic signed [SQ-1:0] ss_s2, cs_s2, cc_s2;
	logic v_s2, bad_s2;

	assign ssf = cy_s[T] * cy_s[T];
	assign csf = cx_s[T] * cy_s[T];
	assign ccf = cx_s[T] * cx_s[T];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= cv_s[T];
		end
	end

	always_ff @(posedge clk) begin
		bad_s2 <= cbad_s[T];
		ss_s2  <= ssf[63:30];
		cs_s2  <= csf[63:30];
		cc_s2  <= ccf[63:30];
	end

	// stage 3: prototype products
	logic signed [SW-1:0] n0ss_s3, n1cs_s3, n2cc_s3, d0ss_s3, d1cs_s3, d2cc_s3;
	logic v_s3, bad_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		bad_s3  <= bad_s2;
		n0ss_s3 <= SW'(num_q[0] * ss_s2);
		n1cs_s3 <= SW'(num_q[1] * cs_s2);
		n2cc_s3 <= SW'(num_q[2] * cc_s2);
		d0ss_s3 <= SW'(den_q[0] * ss_s2);
		d1cs_s3 <= SW'(den_q[1] * cs_s2);
		d2cc_s3 <= SW'(den_q[2] * cc_s2);
	end

	// stage 4: numerator and denominator sums
	logic signed [SW-1:0] num_s4 [0:4];
	logic signed [SW-1:0] den_s4;
	logic v_s4, bad_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		bad_s4    <= bad_s3;
		den_s4    <= d0ss_s3 + d1cs_s3 + d2cc_s3;
		num_s4[0] <= n0ss_s3 + n1cs_s3 + n2cc_s3;
		num_s4[1] <= (n0ss_s3 - n2cc_s3) <<< 1;
		num_s4[2] <= n0ss_s3 - n1cs_s3 + n2cc_s3;
		num_s4[3] <= (d0ss_s3 - d2cc_s3) <<< 1;
		num_s4[4] <= d0ss_s3 - d1cs_s3 + d2cc_s3;
	end

	// stage 5: magnitudes, signs and overflow precheck
	logic [SW-1:0] dmag;
	assign dmag = den_s4[SW-1] ? SW'(-den_s4) : den_s4;

	logic [RW-1:0] qrem_s [0:W+1][0:4];
	logic [W:0]    qq_s   [0:W+1][0:4];
	logic          qneg_s [0:W+1][0:4];
	logic          qhi_s  [0:W+1][0:4];
	logic [SW-1:0] qd_s   [0:W+1];
	logic          qv_s   [0:W+1];
	logic          qbad_s [0:W+1];
	logic          qzero_s[0:W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s[0] <= 1'b0;
		end else begin
			qv_s[0] <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		qbad_s[0]  <= bad_s4;
		qzero_s[0] <= den_s4 == '0;
		qd_s[0]    <= dmag;
	end

	for (genvar l = 0; l < 5; l++) begin : g_lane
		logic [SW-1:0] nmag;
		logic [RW-1:0] r0;
		assign nmag = num_s4[l][SW-1] ? SW'(-num_s4[l]) : num_s4[l];
		assign r0   = RW'(nmag) << (F + 1);

		always_ff @(posedge clk) begin
			qrem_s[0][l] <= r0;
			qq_s[0][l]   <= '0;
			qneg_s[0][l] <= num_s4[l][SW-1] ^ den_s4[SW-1];
			qhi_s[0][l]  <= r0 >= (RW'(dmag) << (W + 1));
		end
	end

	// quotient divider, one bit per stage for all five lanes
	for (genvar k = 0; k <= W; k++) begin : g_qdiv
		localparam int B = W - k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				qv_s[k+1] <= 1'b0;
			end else begin
				qv_s[k+1] <= qv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			qbad_s[k+1]  <= qbad_s[k];
			qzero_s[k+1] <= qzero_s[k];
			qd_s[k+1]    <= qd_s[k];
		end

		for (genvar l = 0; l < 5; l++) begin : g_ql
			logic [RW-1:0] sh;
			logic          geq;
			assign sh  = RW'(qd_s[k]) << B;
			assign geq = qrem_s[k][l] >= sh;

			always_ff @(posedge clk) begin
				qrem_s[k+1][l]   <= geq ? qrem_s[k][l] - sh : qrem_s[k][l];
				qq_s[k+1][l]     <= qq_s[k][l] | ((W + 1)'(geq) << B);
				qneg_s[k+1][l]   <= qneg_s[k][l];
				qhi_s[k+1][l]    <= qhi_s[k][l];
			end
		end
	end

	// rounding and clamping
	logic [W-1:0] coef_val [0:4];
	logic [4:0]   lane_sat;

	for (genvar l = 0; l < 5; l++) begin : g_round
		logic [W+1:0] m, cap, mv;
		assign m   = ((W + 2)'(qq_s[W+1][l]) + 1'b1) >> 1;
		assign cap = qneg_s[W+1][l] ? ((W + 2)'(1) << (W - 1))
		                            : (((W + 2)'(1) << (W - 1)) - 1'b1);
		assign lane_sat[l] = qhi_s[W+1][l] | (m > cap);
		assign mv  = lane_sat[l] ? cap : m;
		assign coef_val[l] = qneg_s[W+1][l] ? W'(-mv) : W'(mv);
	end

	bqc_pkg::status_t st;
	logic             zero_out;

	always_comb begin
		if (qbad_s[W+1]) begin
			st = bqc_pkg::ST_RANGE;
		end else if (qzero_s[W+1]) begin
			st = bqc_pkg::ST_ZERO;
		end else if (|lane_sat) begin
			st = bqc_pkg::ST_SAT;
		end else begin
			st = bqc_pkg::ST_OK;
		end
	end

	assign zero_out = qbad_s[W+1] | qzero_s[W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= qv_s[W+1];
		end
	end

	always_ff @(posedge clk) begin
		status  <= st;
		coef_b0 <= zero_out ? '0 : coef_val[0];
		coef_b1 <= zero_out ? '0 : coef_val[1];
		coef_b2 <= zero_out ? '0 : coef_val[2];
		coef_a1 <= zero_out ? '0 : coef_val[3];
		coef_a2 <= zero_out ? '0 : coef_val[4];
	end

`ifndef NO_ASSERTIONS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without request");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == bqc_pkg::ST_RANGE || status == bqc_pkg::ST_ZERO) |->
		coef_b0 == '0 && coef_b1 == '0 && coef_b2 == '0 && coef_a1 == '0 && coef_a2 == '0)
		else $error("coefficients not cleared on error");

	a_ok_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		qv_s[W+1] && !qbad_s[W+1] && !qzero_s[W+1] && !(|lane_sat) |=>
		status == bqc_pkg::ST_OK)
		else $error("status wrong for clean result");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable |-> pready && !busy)
		else $error("port stalled");
`endif

endmodule

`default_nettype wire

### bench/bqc_checker.sv
// checker: predicts biquad coefficients per cutoff request and compares results
module bqc_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [16:0] cutoff_hz,
	input  wire logic        done,
	input  wire logic [31:0] coef_b0,
	input  wire logic [31:0] coef_b1,
	input  wire logic [31:0] coef_b2,
	input  wire logic [31:0] coef_a1,
	input  wire logic [31:0] coef_a2,
	input  wire logic [1:0]  status,
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import bqc_pkg::*;

	typedef struct packed {
		logic [31:0] b0, b1, b2, a1, a2;
		logic [1:0]  st;
	} coef_set_t;

	logic signed [31:0] proto [6];
	logic [17:0] fs_reg;
	coef_set_t coef_queue [$];

	function automatic longint arctan_q30(int i);
		longint acc, t;
		int e;
		acc = 0;
		if (i == 0) return 843314857;
		for (int n = 0; n < 64; n++) begin
			e = i * (2 * n + 1);
			if (e > 62) break;
			t = longint'((64'd1 << (62 - e)) / (2 * n + 1));
			acc += (n % 2) ? -t : t;
		end
		return longint'((64'(acc) + (64'd1 << 31)) >> 32);
	endfunction

	function automatic logic [31:0] ratio(longint num, longint den, ref bit sat);
		logic [63:0] lim, n, d, q, r, m, cap;
		bit neg, over;
		lim = 64'd1 << 31;
		n = num < 0 ? -num : num;
		d = den < 0 ? -den : den;
		neg = (num < 0) != (den < 0);
		cap = neg ? lim : lim - 1;
		q = n / d;
		r = n % d;
		over = q > 2 * lim + 1;
		for (int k = 0; k <= COEF_FRAC_BITS && !over; k++) begin
			r = r << 1;
			q = q << 1;
			if (r >= d) begin
				r -= d;
				q[0] = 1'b1;
			end
			if (q > 2 * lim + 1) over = 1;
		end
		m = over ? cap : (q + 1) >> 1;
		if (m > cap) begin
			m = cap;
			over = 1;
		end
		if (over) sat = 1;
		if (num == 0) m = 0;
		return neg ? 32'(-m) : 32'(m);
	endfunction

	function automatic coef_set_t bilinear_coefs(logic [16:0] f);
		coef_set_t c;
		longint x, y, z, dx, dy, ss, cs, cc, den, n0, n1, n2, d0, d1, d2;
		bit sat;
		c = '0;
		sat = 0;
		if (f == 0 || 2 * longint'(f) >= longint'(fs_reg)) begin
			c.st = ST_RANGE;
			return c;
		end
		z = longint'((64'd3373259426 * f) / fs_reg);
		x = 536870912;
		y = 0;
		for (int i = 0; i < TAN_ITERATIONS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= arctan_q30(i);
			end else begin
				x += dx; y -= dy; z += arctan_q30(i);
			end
		end
		ss = (y * y) >>> 30;
		cs = (x * y) >>> 30;
		cc = (x * x) >>> 30;
		n0 = proto[0]; n1 = proto[1]; n2 = proto[2];
		d0 = proto[3]; d1 = proto[4]; d2 = proto[5];
		den = d0 * ss + d1 * cs + d2 * cc;
		if (den == 0) begin
			c.st = ST_ZERO;
			return c;
		end
		c.b0 = ratio(n0 * ss + n1 * cs + n2 * cc, den, sat);
		c.b1 = ratio(2 * n0 * ss - 2 * n2 * cc, den, sat);
		c.b2 = ratio(n0 * ss - n1 * cs + n2 * cc, den, sat);
		c.a1 = ratio(2 * d0 * ss - 2 * d2 * cc, den, sat);
		c.a2 = ratio(d0 * ss - d1 * cs + d2 * cc, den, sat);
		c.st = sat ? ST_SAT : ST_OK;
		return c;
	endfunction

	assign pending = coef_queue.size();

	always @(posedge clk or negedge arst_n) begin
		coef_set_t exp_c, got;
		if (!arst_n) begin
			proto[0] <= RST_ONE; proto[1] <= '0; proto[2] <= '0;
			proto[3] <= RST_ONE; proto[4] <= '0; proto[5] <= '0;
			fs_reg <= RST_FS;
			fail_count <= 0;
			coef_queue.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[4:2] < 3'(REG_FS)) proto[paddr[4:2]] <= pwdata;
				else if (paddr[4:2] == 3'(REG_FS)) fs_reg <= pwdata[17:0];
			end
			if (start && !busy) coef_queue.push_back(bilinear_coefs(cutoff_hz));
			if (done) begin
				got = {coef_b0, coef_b1, coef_b2, coef_a1, coef_a2, status};
				if (coef_queue.size() == 0) begin
					$display("%0t: unexpected result %h", $realtime, got);
					fail_count <= fail_count + 1;
				end else begin
					exp_c = coef_queue.pop_front();
					if (got != exp_c) begin
						$display("%0t: mismatch expected %h actual %h", $realtime, exp_c, got);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

### bench/tb.sv
// testbench top: drives cutoff requests and register writes, reports the verdict
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bqc_pkg::*;

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0, prdata;
	logic pready, start = 0, busy, done;
	logic [16:0] cutoff_hz = '0;
	logic [31:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
	logic [1:0] status;
	int fail_count, pending;
	int cycles = 0;

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	biquad_bilinear_coefficient_gen i_dut (.*);
	bqc_checker i_chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("biquad_bilinear_coefficient_gen verification failed");
			$finish;
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [31:0] v);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic send_cutoff(logic [16:0] f, bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 17) : 0;
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1; cutoff_hz <= f;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic wait_empty();
		start <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic drain();
		wait_empty();
		repeat (100) @(posedge clk);
	endtask

	task automatic random_proto(int mode);
		for (int r = 0; r < 6; r++) begin
			case (mode)
				0: write_reg(reg_idx_t'(r), $urandom);
				1: write_reg(reg_idx_t'(r), 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25)));
				default: write_reg(reg_idx_t'(r), (r % 3 == 1) ? 32'h0 : 32'd16777216);
			endcase
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: field extremes and special cases at reset settings
		send_cutoff(0, 0);
		send_cutoff(1, 0);
		send_cutoff(23999, 0);
		send_cutoff(24000, 0);
		send_cutoff(17'h1ffff, 0);
		send_cutoff(1000, 0);
		drain();
		write_reg(REG_DEN_C0, 0);
		send_cutoff(1000, 0);
		drain();
		write_reg(REG_NUM_C0, 32'h7fffffff);
		write_reg(REG_NUM_C1, 32'h80000000);
		write_reg(REG_NUM_C2, 32'h7fffffff);
		write_reg(REG_DEN_C0, 32'h00000001);
		write_reg(REG_DEN_C1, 32'h00000001);
		write_reg(REG_DEN_C2, 32'h80000000);
		write_reg(REG_FS, 32'hfffc0000 | 18'd8000);
		send_cutoff(1, 0);
		send_cutoff(3999, 0);
		send_cutoff(4000, 0);
		drain();
		write_reg(REG_FS, 192000);
		send_cutoff(95999, 0);
		send_cutoff(96000, 0);
		send_cutoff(50, 0);
		drain();
		write_reg(REG_FS, 0);
		send_cutoff(5, 0);
		drain();
		for (int ph = 0; ph < 6; ph++) begin
			random_proto(ph % 3);
			write_reg(REG_FS, ph == 0 ? 8000 : ph == 1 ? 192000 :
				$urandom_range(8000, 192000));
			for (int n = 0; n < 100; n++) begin
				if ($urandom_range(0, 9) == 0) send_cutoff($urandom, ph != 3);
				else send_cutoff($urandom_range(0, 96000), ph != 3);
				if (n == 50 && ph == 2) wait_empty();
			end
			drain();
		end
		if (fail_count == 0)
			$display("biquad_bilinear_coefficient_gen verification clean");
		else
			$display("biquad_bilinear_coefficient_gen verification failed");
		$finish;
	end
endmodule

### sim.f
rtl/core/bqc_pkg.sv
rtl/core/biquad_bilinear_coefficient_gen.sv
bench/bqc_checker.sv
bench/tb.sv
